FILE: rtl/rmc_pkg.sv
// Shared types, codes and helper function of the random maze carver.
// No dependencies; used by rmc_div, rmc_core and random_maze_carver_top.
package rmc_pkg;

  localparam int RAND_W       = 16;
  localparam int CNT_OUT_W    = 11;
  localparam int COORD_OUT_W  = 5;
  localparam int DIM_REG_W    = 6;
  localparam int DEF_ACROSS   = 32;
  localparam int DEF_DOWN     = 32;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic REG_ACROSS = 1'b0;
  localparam logic REG_DOWN   = 1'b1;

  localparam logic [1:0] DIR_LEFT  = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_UP    = 2'd2;
  localparam logic [1:0] DIR_DOWN  = 2'd3;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIVC, S_DIVR, S_DIVP, S_FRD,
    S_NBR, S_NBC, S_DIVS, S_SH, S_EMIT
  } state_t;

  typedef struct packed {
    logic                   carved;
    logic [COORD_OUT_W-1:0] col;
    logic [COORD_OUT_W-1:0] row;
    logic [1:0]             dir;
    logic [CNT_OUT_W-1:0]   count;
    logic                   done;
  } rmc_res_t;

  // Returns the sel-th set bit position of ok, counting from bit 0.
  function automatic logic [1:0] pick_dir(input logic [3:0] ok, input logic [1:0] sel);
    logic [1:0] cnt;
    logic [1:0] res;
    logic       found;
    cnt   = 2'd0;
    res   = DIR_LEFT;
    found = 1'b0;
    for (int d = 0; d < 4; d++) begin
      if (ok[d] && !found) begin
        if (cnt == sel) begin
          res   = 2'(d);
          found = 1'b1;
        end
        cnt = cnt + 2'd1;
      end
    end
    return res;
  endfunction

endpackage

FILE: rtl/random_maze_carver_top.sv
// Top level of the random maze carver: configuration registers, output register
// and the carving sequencer. Depends on rmc_pkg, rmc_core and rmc_div.
//
// Usage. Commands arrive on the in_ stream: in_tuser carries the command (start
// a new maze or take one growth step) and in_tdata the two random words. Every
// accepted transaction yields exactly one result transaction on the out_ stream,
// reporting the start or picked node, whether a passage was carved and in which
// direction, and the frontier size afterwards.
// Sequence. A start transaction first sweeps the whole visited map, one node a
// cycle, then runs two remainders on the shared divider, for the column and
// the row. A step runs one remainder for the frontier pick, reads the entry,
// tests the four neighbors one after another and then either a second
// remainder for the direction or the order-keeping removal, which moves one
// frontier entry per cycle. A step on an empty frontier only reports done.
// The divider is shared and the frontier memory has one read and one write
// port; one transaction is in work at a time.
// Reset. After rst_n the block clears the visited map in the same sweep before
// in_tready rises; configuration writes are taken throughout. When the receiver
// stalls, the result waits in the output register, the next command can still
// be accepted and processed, and the core holds its next result until the
// output register is free.
module random_maze_carver_top #(
  parameter int MAX_ACROSS = rmc_pkg::DEF_ACROSS,
  parameter int MAX_DOWN   = rmc_pkg::DEF_DOWN
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // rand_a [15:0], rand_b [31:16]
  input  logic [0:0]  in_tuser,   // command [0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // carved [0], node_col [5:1], node_row [10:6], carve_dir [12:11],
  // frontier_count [23:13], done_res [24], zero fill [31:25]
  output logic [31:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int FC_W = $clog2(MAX_ACROSS * MAX_DOWN + 1);

  logic [rmc_pkg::DIM_REG_W-1:0] across_r, across_nxt, down_r, down_nxt;
  logic [FC_W-1:0]               across_eff, down_eff;
  logic                          cfg_wr;
  logic                          res_vld, res_rdy;
  rmc_pkg::rmc_res_t             res;
  logic                          out_v_r, out_v_nxt;
  rmc_pkg::rmc_res_t             out_r, out_nxt;

  // Register writes complete in the APB access phase; pready is tied high.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    across_nxt = across_r;
    down_nxt   = down_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        rmc_pkg::REG_ACROSS: across_nxt = cfg_pwdata[rmc_pkg::DIM_REG_W-1:0];
        rmc_pkg::REG_DOWN:   down_nxt   = cfg_pwdata[rmc_pkg::DIM_REG_W-1:0];
        default:             across_nxt = across_r;
      endcase
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == rmc_pkg::REG_DOWN) ? 32'(down_r) : 32'(across_r);

  // A zero dimension counts as one, and anything above the build maximum
  // counts as that maximum.
  assign across_eff = (across_r == '0) ? FC_W'(1) :
                      (int'(across_r) > MAX_ACROSS) ? FC_W'(MAX_ACROSS) : FC_W'(across_r);
  assign down_eff   = (down_r == '0) ? FC_W'(1) :
                      (int'(down_r) > MAX_DOWN) ? FC_W'(MAX_DOWN) : FC_W'(down_r);

  rmc_core #(.MAX_ACROSS(MAX_ACROSS), .MAX_DOWN(MAX_DOWN)) u_core (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_cmd(in_tuser[0]), .in_ra(in_tdata[15:0]), .in_rb(in_tdata[31:16]),
    .across(across_eff), .down(down_eff),
    .res_vld(res_vld), .res_rdy(res_rdy), .res(res)
  );

  // Output register: takes a new result whenever it is empty or being drained.
  assign res_rdy = !out_v_r || out_tready;

  always_comb begin
    out_v_nxt = out_v_r;
    out_nxt   = out_r;
    if (res_rdy) begin
      out_v_nxt = res_vld;
      if (res_vld) out_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      across_r <= rmc_pkg::DIM_REG_W'(rmc_pkg::DEF_ACROSS);
      down_r   <= rmc_pkg::DIM_REG_W'(rmc_pkg::DEF_DOWN);
      out_v_r  <= 1'b0;
    end else begin
      across_r <= across_nxt;
      down_r   <= down_nxt;
      out_v_r  <= out_v_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_r.done, out_r.count, out_r.dir,
                       out_r.row, out_r.col, out_r.carved};

endmodule

FILE: rtl/rmc_div.sv
// Shared restoring divider: one remainder bit per cycle over a random word.
// Depends on rmc_pkg for the random word width.
module rmc_div #(
  parameter int DV_W = 11
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       go,
  input  logic [rmc_pkg::RAND_W-1:0] dividend,
  input  logic [DV_W-1:0]            divisor,
  output logic                       busy,
  output logic                       done,
  output logic [DV_W-1:0]            rem
);

  localparam int CW = $clog2(rmc_pkg::RAND_W);

  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic [rmc_pkg::RAND_W-1:0] q_r, q_nxt;
  logic [DV_W:0]              rem_r, rem_nxt;
  logic [DV_W-1:0]            dv_r, dv_nxt;
  logic [DV_W:0]              trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dv_nxt   = dv_r;
    trial    = {rem_r[DV_W-1:0], q_r[rmc_pkg::RAND_W-1]};
    if (go) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dv_nxt   = divisor;
    end else if (busy_r) begin
      q_nxt   = {q_r[rmc_pkg::RAND_W-2:0], 1'b0};
      rem_nxt = (trial >= {1'b0, dv_r}) ? trial - {1'b0, dv_r} : trial;
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(rmc_pkg::RAND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dv_r  <= dv_nxt;
  end

  assign busy = busy_r;
  assign done = done_r;
  assign rem  = rem_r[DV_W-1:0];

endmodule

FILE: rtl/rmc_core.sv
// Carving sequencer with the visited map and frontier list memories.
// Depends on rmc_pkg and instantiates the shared divider rmc_div.
module rmc_core #(
  parameter int MAX_ACROSS = rmc_pkg::DEF_ACROSS,
  parameter int MAX_DOWN   = rmc_pkg::DEF_DOWN
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_cmd,
  input  logic [rmc_pkg::RAND_W-1:0] in_ra,
  input  logic [rmc_pkg::RAND_W-1:0] in_rb,
  input  logic [$clog2(MAX_ACROSS*MAX_DOWN+1)-1:0] across,
  input  logic [$clog2(MAX_ACROSS*MAX_DOWN+1)-1:0] down,
  output logic                       res_vld,
  input  logic                       res_rdy,
  output rmc_pkg::rmc_res_t          res
);

  localparam int NODE_CAP = MAX_ACROSS * MAX_DOWN;
  localparam int FC_W = $clog2(NODE_CAP + 1);
  localparam int AW   = (NODE_CAP > 1) ? $clog2(NODE_CAP) : 1;
  localparam int CW   = (MAX_ACROSS > 1) ? $clog2(MAX_ACROSS) : 1;
  localparam int RW   = (MAX_DOWN > 1) ? $clog2(MAX_DOWN) : 1;
  localparam int EW   = CW + RW;

  rmc_pkg::state_t   state_r, state_nxt;
  logic [AW-1:0]     clr_a_r, clr_a_nxt;
  logic              item_r, item_nxt;
  logic [rmc_pkg::RAND_W-1:0] ra_r, ra_nxt, rb_r, rb_nxt;
  logic [FC_W-1:0]   size_r, size_nxt, pick_r, pick_nxt, j_r, j_nxt;
  logic [CW-1:0]     col_r, col_nxt;
  logic [RW-1:0]     row_r, row_nxt;
  logic [3:0]        ok_r, ok_nxt, okn;
  logic [1:0]        d_r, d_nxt, dir;
  logic              sh_v_r, sh_v_nxt;
  logic [AW-1:0]     sh_a_r, sh_a_nxt;
  rmc_pkg::rmc_res_t res_r, res_nxt;

  logic          vis_mem_r [NODE_CAP];
  logic [EW-1:0] fl_mem_r [NODE_CAP];
  logic          vis_q_r;
  logic [EW-1:0] fl_q_r;
  logic          vis_we, vis_wd;
  logic [AW-1:0] vis_wa, vis_ra;
  logic          fl_we;
  logic [AW-1:0] fl_wa, fl_ra;
  logic [EW-1:0] fl_wd;

  logic                       div_go, div_busy, div_done;
  logic [rmc_pkg::RAND_W-1:0] div_dnd;
  logic [FC_W-1:0]            div_dvs, div_rem;
  logic [CW-1:0]              fcol, ncol;
  logic [RW-1:0]              frow, nrow;
  logic [FC_W-1:0]            nsel;

  rmc_div #(.DV_W(FC_W)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .dividend(div_dnd), .divisor(div_dvs),
    .busy(div_busy), .done(div_done), .rem(div_rem)
  );

  function automatic logic [AW-1:0] node_addr(input logic [CW-1:0] c, input logic [RW-1:0] r);
    return AW'(AW'(r) * AW'(MAX_ACROSS)) + AW'(c);
  endfunction

  // Neighbor coordinates of the current node in direction sel.
  function automatic logic [EW-1:0] nb_coord(input logic [CW-1:0] c, input logic [RW-1:0] r,
                                             input logic [1:0] sel);
    logic [CW-1:0] nc;
    logic [RW-1:0] nr;
    nc = c;
    nr = r;
    unique case (sel)
      rmc_pkg::DIR_LEFT:  nc = c - CW'(1);
      rmc_pkg::DIR_RIGHT: nc = c + CW'(1);
      rmc_pkg::DIR_UP:    nr = r - RW'(1);
      rmc_pkg::DIR_DOWN:  nr = r + RW'(1);
      default:            nc = c;
    endcase
    return {nr, nc};
  endfunction

  always_comb begin
    state_nxt = state_r;
    clr_a_nxt = clr_a_r;
    item_nxt  = item_r;
    ra_nxt    = ra_r;
    rb_nxt    = rb_r;
    size_nxt  = size_r;
    pick_nxt  = pick_r;
    j_nxt     = j_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    ok_nxt    = ok_r;
    d_nxt     = d_r;
    sh_v_nxt  = 1'b0;
    sh_a_nxt  = sh_a_r;
    res_nxt   = res_r;
    in_ready  = 1'b0;
    res_vld   = 1'b0;
    vis_we    = 1'b0;
    vis_wa    = clr_a_r;
    vis_wd    = 1'b0;
    vis_ra    = '0;
    fl_we     = 1'b0;
    fl_wa     = sh_a_r;
    fl_wd     = fl_q_r;
    fl_ra     = '0;
    div_go    = 1'b0;
    div_dnd   = ra_r;
    div_dvs   = size_r;
    okn       = ok_r;
    nsel      = '0;
    fcol      = fl_q_r[CW-1:0];
    frow      = fl_q_r[EW-1:CW];
    {nrow, ncol} = nb_coord(col_r, row_r, d_r);
    dir       = rmc_pkg::pick_dir(ok_r, 2'(div_rem));

    unique case (state_r)
      rmc_pkg::S_CLR: begin
        vis_we    = 1'b1;
        clr_a_nxt = clr_a_r + AW'(1);
        if (clr_a_r == AW'(NODE_CAP - 1)) begin
          if (item_r) begin
            item_nxt  = 1'b0;
            div_go    = 1'b1;
            div_dvs   = across;
            state_nxt = rmc_pkg::S_DIVC;
          end else begin
            state_nxt = rmc_pkg::S_IDLE;
          end
        end
      end
      rmc_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ra_nxt = in_ra;
          rb_nxt = in_rb;
          if (in_cmd == rmc_pkg::CMD_START) begin
            clr_a_nxt = '0;
            item_nxt  = 1'b1;
            state_nxt = rmc_pkg::S_CLR;
          end else if (size_r == '0) begin
            res_nxt      = '0;
            res_nxt.done = 1'b1;
            state_nxt    = rmc_pkg::S_EMIT;
          end else begin
            div_go    = 1'b1;
            div_dnd   = in_ra;
            state_nxt = rmc_pkg::S_DIVP;
          end
        end
      end
      rmc_pkg::S_DIVC: begin
        if (div_done) begin
          col_nxt   = CW'(div_rem);
          div_go    = 1'b1;
          div_dnd   = rb_r;
          div_dvs   = down;
          state_nxt = rmc_pkg::S_DIVR;
        end
      end
      rmc_pkg::S_DIVR: begin
        if (div_done) begin
          row_nxt       = RW'(div_rem);
          vis_we        = 1'b1;
          vis_wa        = node_addr(col_r, RW'(div_rem));
          vis_wd        = 1'b1;
          fl_we         = 1'b1;
          fl_wa         = '0;
          fl_wd         = {RW'(div_rem), col_r};
          size_nxt      = FC_W'(1);
          res_nxt       = '0;
          res_nxt.col   = rmc_pkg::COORD_OUT_W'(col_r);
          res_nxt.row   = rmc_pkg::COORD_OUT_W'(RW'(div_rem));
          res_nxt.count = rmc_pkg::CNT_OUT_W'(1);
          state_nxt     = rmc_pkg::S_EMIT;
        end
      end
      rmc_pkg::S_DIVP: begin
        fl_ra = AW'(div_rem);
        if (div_done) begin
          pick_nxt  = div_rem;
          state_nxt = rmc_pkg::S_FRD;
        end
      end
      rmc_pkg::S_FRD: begin
        col_nxt   = fcol;
        row_nxt   = frow;
        ok_nxt[0] = (FC_W'(fcol) < across) && (FC_W'(frow) < down) && (fcol != '0);
        ok_nxt[1] = (FC_W'(fcol) < across) && (FC_W'(frow) < down)
                    && (FC_W'(fcol) + FC_W'(1) < across);
        ok_nxt[2] = (FC_W'(fcol) < across) && (FC_W'(frow) < down) && (frow != '0);
        ok_nxt[3] = (FC_W'(fcol) < across) && (FC_W'(frow) < down)
                    && (FC_W'(frow) + FC_W'(1) < down);
        d_nxt     = rmc_pkg::DIR_LEFT;
        state_nxt = rmc_pkg::S_NBR;
      end
      rmc_pkg::S_NBR: begin
        vis_ra    = node_addr(ncol, nrow);
        state_nxt = rmc_pkg::S_NBC;
      end
      rmc_pkg::S_NBC: begin
        if (ok_r[d_r] && vis_q_r) okn[d_r] = 1'b0;
        ok_nxt = okn;
        nsel   = FC_W'(3'(okn[0]) + 3'(okn[1]) + 3'(okn[2]) + 3'(okn[3]));
        if (d_r == rmc_pkg::DIR_DOWN) begin
          if (okn == '0) begin
            j_nxt     = pick_r + FC_W'(1);
            state_nxt = rmc_pkg::S_SH;
          end else begin
            div_go    = 1'b1;
            div_dnd   = rb_r;
            div_dvs   = nsel;
            state_nxt = rmc_pkg::S_DIVS;
          end
        end else begin
          d_nxt     = d_r + 2'd1;
          state_nxt = rmc_pkg::S_NBR;
        end
      end
      rmc_pkg::S_DIVS: begin
        {nrow, ncol} = nb_coord(col_r, row_r, dir);
        if (div_done) begin
          vis_we = 1'b1;
          vis_wa = node_addr(ncol, nrow);
          vis_wd = 1'b1;
          if (size_r < FC_W'(NODE_CAP)) begin
            fl_we    = 1'b1;
            fl_wa    = AW'(size_r);
            fl_wd    = {nrow, ncol};
            size_nxt = size_r + FC_W'(1);
          end
          res_nxt        = '0;
          res_nxt.carved = 1'b1;
          res_nxt.col    = rmc_pkg::COORD_OUT_W'(col_r);
          res_nxt.row    = rmc_pkg::COORD_OUT_W'(row_r);
          res_nxt.dir    = dir;
          res_nxt.count  = rmc_pkg::CNT_OUT_W'(size_nxt);
          state_nxt      = rmc_pkg::S_EMIT;
        end
      end
      rmc_pkg::S_SH: begin
        fl_we = sh_v_r;
        if (j_r < size_r) begin
          fl_ra    = AW'(j_r);
          sh_v_nxt = 1'b1;
          sh_a_nxt = AW'(j_r - FC_W'(1));
          j_nxt    = j_r + FC_W'(1);
        end else if (!sh_v_r) begin
          size_nxt      = size_r - FC_W'(1);
          res_nxt       = '0;
          res_nxt.col   = rmc_pkg::COORD_OUT_W'(col_r);
          res_nxt.row   = rmc_pkg::COORD_OUT_W'(row_r);
          res_nxt.count = rmc_pkg::CNT_OUT_W'(size_nxt);
          res_nxt.done  = (size_nxt == '0);
          state_nxt     = rmc_pkg::S_EMIT;
        end
      end
      rmc_pkg::S_EMIT: begin
        res_vld = 1'b1;
        if (res_rdy) state_nxt = rmc_pkg::S_IDLE;
      end
      default: state_nxt = rmc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rmc_pkg::S_CLR;
      clr_a_r <= '0;
      item_r  <= 1'b0;
      size_r  <= '0;
      sh_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_a_r <= clr_a_nxt;
      item_r  <= item_nxt;
      size_r  <= size_nxt;
      sh_v_r  <= sh_v_nxt;
    end
    ra_r   <= ra_nxt;
    rb_r   <= rb_nxt;
    pick_r <= pick_nxt;
    j_r    <= j_nxt;
    col_r  <= col_nxt;
    row_r  <= row_nxt;
    ok_r   <= ok_nxt;
    d_r    <= d_nxt;
    sh_a_r <= sh_a_nxt;
    res_r  <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem_r[vis_wa] <= vis_wd;
    vis_q_r <= vis_mem_r[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (fl_we) fl_mem_r[fl_wa] <= fl_wd;
    fl_q_r <= fl_mem_r[fl_ra];
  end

  assign res = res_r;

  a_size_cap: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= FC_W'(NODE_CAP)) else $error("frontier count beyond capacity");
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_go |-> !div_busy) else $error("divider started while busy");
  a_shift_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rmc_pkg::S_SH && sh_v_r) |-> (FC_W'(sh_a_r) + FC_W'(1) < size_r))
    else $error("shift write outside frontier");
  a_carve_live: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res.carved) |-> (!res.done && res.count > rmc_pkg::CNT_OUT_W'(1)))
    else $error("carve reported with too small frontier");

endmodule
